// ----- hdl/swm_pkg.sv -----
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 16;
    localparam int WLEN_WIDTH   = 7;
    localparam int POS_WIDTH    = 16;
    localparam int CELL_IDX_W   = $clog2(MAX_WINDOW);
    localparam int WEFF_W       = $clog2(MAX_WINDOW + 1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [WLEN_WIDTH-1:0]          wlen_t;
    typedef logic [POS_WIDTH-1:0]           pos_t;
    typedef logic [CELL_IDX_W-1:0]          cell_idx_t;
    typedef logic [WEFF_W-1:0]              weff_t;

    localparam wlen_t   WLEN_RESET = wlen_t'(3);
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic      advance;
        logic      restart;
        cell_idx_t sel;
    } swm_ctl_t;

endpackage

// ----- hdl/swm_cell.sv -----
module swm_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  swm_pkg::sample_t sample,
    input  logic             link_valid,
    input  swm_pkg::sample_t link_max,
    output logic             valid,
    output swm_pkg::sample_t run_max
);
    import swm_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sample_t max_reg;
    sample_t max_next;

    always_comb
    begin
        valid_next = valid_reg;
        max_next   = max_reg;
        if (advance)
        begin
            valid_next = link_valid;
            max_next   = (link_valid && (link_max > sample)) ? link_max : sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
    end

    assign valid   = valid_reg;
    assign run_max = max_reg;

endmodule

// ----- hdl/swm_ctrl.sv -----
module swm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  swm_pkg::wlen_t   window_length,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             sequence_start,
    input  swm_pkg::sample_t cand_max,
    output swm_pkg::swm_ctl_t ctl,
    output logic             out_valid,
    input  logic             out_stall,
    output swm_pkg::sample_t window_max,
    output swm_pkg::pos_t    end_position
);
    import swm_pkg::*;

    wlen_t   wlen_reg;
    wlen_t   wlen_next;
    pos_t    count_reg;
    pos_t    count_next;
    weff_t   seen_reg;
    weff_t   seen_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    sample_t max_reg;
    sample_t max_next;
    pos_t    pos_reg;
    pos_t    pos_next;

    weff_t   w_eff;
    weff_t   seen_base;
    pos_t    pos;
    logic    accept;
    logic    emit;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            w_eff = weff_t'(1);
        end
        else if (int'(wlen_reg) > MAX_WINDOW)
        begin
            w_eff = weff_t'(MAX_WINDOW);
        end
        else
        begin
            w_eff = weff_t'(wlen_reg);
        end
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    assign ctl.advance = accept;
    assign ctl.restart = sequence_start;
    assign ctl.sel     = cell_idx_t'(w_eff - weff_t'(1));

    always_comb
    begin
        wlen_next      = wlen_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        max_next       = max_reg;
        pos_next       = pos_reg;
        pos            = sequence_start ? '0 : count_reg;
        seen_base      = sequence_start ? '0 : seen_reg;
        emit           = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            wlen_next = window_length;
        end

        if (seen_base > w_eff)
        begin
            seen_base = w_eff;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            count_next = pos + pos_t'(1);
            seen_next  = (seen_base < w_eff) ? seen_base + weff_t'(1) : seen_base;
            emit       = (seen_next == w_eff);
            out_valid_next = emit;
            if (emit)
            begin
                max_next = cand_max;
                pos_next = pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg      <= WLEN_RESET;
            count_reg     <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg      <= wlen_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        pos_reg <= pos_next;
    end

    assign out_valid    = out_valid_reg;
    assign window_max   = max_reg;
    assign end_position = pos_reg;

endmodule

// ----- hdl/sliding_window_maximum.sv -----
// Channel   Direction  Handshake           Payload
// cfg       in         cfg_valid/cfg_ready window_length
// in        in         in_valid/in_stall   sample_value, sequence_start
// out       out        out_valid/out_stall window_max, end_position
//
// One sample is taken per cycle unless stalled; its result, if any, appears
// in the output register on the next cycle. Cell k of the chain holds the
// maximum of the last k+1 samples, so each transfer updates every cell at once.
// Reset clears all valid bits, the counters and sets window_length to 3.
// in_stall rises only while a result sits in the output register under stall.
module sliding_window_maximum (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  swm_pkg::wlen_t   window_length,
    input  logic             in_valid,
    output logic             in_stall,
    input  swm_pkg::sample_t sample_value,
    input  logic             sequence_start,
    output logic             out_valid,
    input  logic             out_stall,
    output swm_pkg::sample_t window_max,
    output swm_pkg::pos_t    end_position
);
    import swm_pkg::*;

    swm_ctl_t ctl;
    logic     link_valid [MAX_WINDOW];
    sample_t  link_max   [MAX_WINDOW];
    logic     cell_valid [MAX_WINDOW-1];
    sample_t  cell_max   [MAX_WINDOW-1];
    sample_t  cand_max;

    assign link_valid[0] = 1'b1;
    assign link_max[0]   = SAMPLE_MIN;

    for (genvar i = 0; i < MAX_WINDOW - 1; i++)
    begin : g_cell
        assign link_valid[i+1] = cell_valid[i] && !ctl.restart;
        assign link_max[i+1]   = cell_max[i];

        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (ctl.advance),
            .sample     (sample_value),
            .link_valid (link_valid[i]),
            .link_max   (link_max[i]),
            .valid      (cell_valid[i]),
            .run_max    (cell_max[i])
        );
    end

    assign cand_max = (link_valid[ctl.sel] && (link_max[ctl.sel] > sample_value))
                      ? link_max[ctl.sel] : sample_value;

    swm_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .window_length  (window_length),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sequence_start (sequence_start),
        .cand_max       (cand_max),
        .ctl            (ctl),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_max     (window_max),
        .end_position   (end_position)
    );

endmodule

// ----- bench/sliding_window_maximum_test.sv -----
`timescale 1ns / 100ps

module sliding_window_maximum_test;

    import swm_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        sample_t peak;
        pos_t    position;
    } window_result_t;

    typedef enum int {RANDOM_DATA, NEAR_ZERO, FALLING, RISING, EXTREMES} data_shape_t;

    logic    clk            = 1'b0;
    logic    rst_n          = 1'b0;
    logic    cfg_valid      = 1'b0;
    logic    cfg_ready;
    wlen_t   window_length  = WLEN_RESET;
    logic    in_valid       = 1'b0;
    logic    in_stall;
    sample_t sample_value   = '0;
    logic    sequence_start = 1'b0;
    logic    out_valid;
    logic    out_stall      = 1'b0;
    sample_t window_max;
    pos_t    end_position;

    // predictor state
    sample_t cand_value [MAX_WINDOW];
    pos_t    cand_pos   [MAX_WINDOW];
    int      cand_head;
    int      cand_count;
    pos_t    next_pos;
    int      fill_level;
    wlen_t   window_reg;

    window_result_t pending_maxima [$];

    logic idling = 1'b1;
    int   samples_sent;
    int   maxima_checked;
    int   window_writes;
    int   mismatches;
    int   quiet_cycles;

    sliding_window_maximum u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .window_length  (window_length),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .sequence_start (sequence_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .window_max     (window_max),
        .end_position   (end_position)
    );

    always #10 clk = ~clk;

    function automatic int effective_window(input wlen_t len);
        if (len == 0)
            return 1;
        if (len > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(len);
    endfunction

    function automatic void reset_predictor();
        cand_head  = 0;
        cand_count = 0;
        next_pos   = '0;
        fill_level = 0;
        window_reg = WLEN_RESET;
    endfunction

    function automatic void predict_window_max(input sample_t value, input logic start);
        int             w;
        pos_t           p;
        pos_t           age;
        window_result_t res;
        w = effective_window(window_reg);
        if (start)
        begin
            cand_head  = 0;
            cand_count = 0;
            next_pos   = '0;
            fill_level = 0;
        end
        p = next_pos;
        // drop tail entries not above the new sample
        while (cand_count > 0 &&
               cand_value[(cand_head + cand_count - 1) % MAX_WINDOW] <= value)
            cand_count--;
        // drop head entries outside the window
        forever
        begin
            if (cand_count == 0)
                break;
            age = p - cand_pos[cand_head];
            if (age < w)
                break;
            cand_head = (cand_head + 1) % MAX_WINDOW;
            cand_count--;
        end
        if (cand_count >= MAX_WINDOW)
        begin
            cand_head = (cand_head + 1) % MAX_WINDOW;
            cand_count--;
        end
        cand_value[(cand_head + cand_count) % MAX_WINDOW] = value;
        cand_pos[(cand_head + cand_count) % MAX_WINDOW]   = p;
        cand_count++;
        next_pos = p + 1'b1;
        if (fill_level > w)
            fill_level = w;
        if (fill_level < w)
            fill_level++;
        if (fill_level >= w)
        begin
            res.peak     = cand_value[cand_head];
            res.position = p;
            pending_maxima = {pending_maxima, res};
        end
    endfunction

    task automatic send_sample(input sample_t value, input logic start);
        int gap;
        gap = idling ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        sample_value   <= value;
        sequence_start <= start;
        do @(posedge clk); while (in_stall);
        predict_window_max(value, start);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_maxima.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_window_length(input wlen_t len);
        drain_results();
        cfg_valid     <= 1'b1;
        window_length <= len;
        do @(posedge clk); while (!cfg_ready);
        window_reg = len;
        window_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_window();
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd2, 1'b0);
    endtask

    task automatic test_extreme_samples();
        write_window_length(wlen_t'(2));
        send_sample(~SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b1);
        write_window_length(wlen_t'(1));
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(~SAMPLE_MIN, 1'b0);
    endtask

    task automatic test_window_limits();
        write_window_length(wlen_t'(MAX_WINDOW));
        send_sample(16'sd100, 1'b1);
        send_sample(16'sd99, 1'b0);
        write_window_length(wlen_t'(0));
        send_sample(-16'sd3, 1'b0);
        write_window_length(wlen_t'(127));
        send_sample(16'sd42, 1'b0);
    endtask

    task automatic test_window_change_mid_sequence();
        write_window_length(wlen_t'(6));
        send_sample(16'sd50, 1'b1);
        send_sample(16'sd40, 1'b0);
        send_sample(16'sd30, 1'b0);
        send_sample(16'sd20, 1'b0);
        send_sample(16'sd10, 1'b0);
        write_window_length(wlen_t'(3));
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd1, 1'b0);
        write_window_length(wlen_t'(5));
        send_sample(-16'sd2, 1'b0);
        send_sample(-16'sd4, 1'b0);
        send_sample(-16'sd6, 1'b0);
    endtask

    task automatic test_random_sequences();
        wlen_t       fixed_lengths [6];
        wlen_t       len;
        data_shape_t shape;
        sample_t     level;
        sample_t     value;
        logic        start;
        int          w;
        int          seq_left;
        int          step;
        fixed_lengths = '{wlen_t'(1), wlen_t'(MAX_WINDOW), wlen_t'(0), wlen_t'(127),
                          wlen_t'(2), wlen_t'(3)};
        shape = RANDOM_DATA;
        level = '0;
        step  = 1;
        for (int phase = 0; phase < 10; phase++)
        begin
            idling = ($urandom_range(0, 3) != 0);
            len = (phase < 6) ? fixed_lengths[phase] : wlen_t'($urandom_range(1, MAX_WINDOW));
            write_window_length(len);
            w = effective_window(len);
            seq_left = 0;
            for (int i = 0; i < 140; i++)
            begin
                if (i == 70)
                    drain_results();
                start = 1'b0;
                if (seq_left == 0)
                begin
                    start = ($urandom_range(0, 9) != 0);
                    if ($urandom_range(0, 5) == 0)
                        seq_left = $urandom_range(1, w);
                    else
                        seq_left = $urandom_range(w, 3 * w + 8);
                    shape = data_shape_t'($urandom_range(0, 4));
                    level = sample_t'($urandom);
                    step  = $urandom_range(1, 2000);
                end
                else if ($urandom_range(0, 39) == 0)
                    start = 1'b1;
                case (shape)
                    RANDOM_DATA: value = sample_t'($urandom);
                    NEAR_ZERO:   value = sample_t'(int'($urandom_range(0, 6)) - 3);
                    FALLING:
                    begin
                        level = sample_t'(level - step);
                        value = level;
                    end
                    RISING:
                    begin
                        level = sample_t'(level + step);
                        value = level;
                    end
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0:       value = SAMPLE_MIN;
                            1:       value = ~SAMPLE_MIN;
                            2:       value = '0;
                            default: value = '1;
                        endcase
                    end
                endcase
                send_sample(value, start);
                seq_left--;
            end
        end
        idling = 1'b1;
    endtask

    initial
    begin
        int gap;
        window_result_t want;
        @(negedge clk);
        forever
        begin
            gap = idling ? $urandom_range(0, 14) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (pending_maxima.size() == 0)
            begin
                $error("unexpected result: window_max %0d end_position %0d",
                       window_max, end_position);
                mismatches++;
            end
            else
            begin
                want = pending_maxima[0];
                pending_maxima.delete(0);
                maxima_checked++;
                if (window_max !== want.peak)
                begin
                    $error("window_max: expected %0d, got %0d", $signed(want.peak),
                           window_max);
                    mismatches++;
                end
                if (end_position !== want.position)
                begin
                    $error("end_position: expected %0d, got %0d", want.position,
                           end_position);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending_maxima.size());
            $display("FAIL sliding_window_maximum");
            $finish;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        reset_predictor();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_window();
        test_extreme_samples();
        test_window_limits();
        test_window_change_mid_sequence();
        test_random_sequences();
        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d samples, %0d maxima checked, %0d window length writes",
                 samples_sent, maxima_checked, window_writes);
        $display("lengths 0 to 127, restarts, short sequences, mid-run resizing, stalls");
        if (mismatches == 0)
            $display("PASS sliding_window_maximum");
        else
            $display("FAIL sliding_window_maximum");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/swm_ctrl.sv
hdl/sliding_window_maximum.sv
bench/sliding_window_maximum_test.sv
